@@ rtl/refcount_delta_cache_defines.svh @@
// Assertion macros for the reference-count delta cache.
`ifndef REFCOUNT_DELTA_CACHE_DEFINES_SVH
`define REFCOUNT_DELTA_CACHE_DEFINES_SVH

// expr must hold at every edge outside reset
`define RDC_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define RDC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/rdc_pkg.sv @@
// Shared types and constants for the reference-count delta cache.
`timescale 1ns / 1ps

package rdc_pkg;

   typedef enum logic [1:0] {
      OP_INC  = 2'd0,
      OP_DEC  = 2'd1,
      OP_TICK = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_EVICT = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_SKIP  = 2'd2
   } kind_type;

   localparam logic [31:0]        HASH_MUL  = 32'h9E37_0001;
   localparam logic signed [31:0] DELTA_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] DELTA_MIN = 32'sh8000_0000;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // classified item handed from front to back (slot index rides beside it)
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] id;
      logic [31:0] epoch;
   } cmd_type;

   typedef struct packed {
      kind_type           kind;
      logic [31:0]        id;
      logic signed [31:0] delta;
      logic               last;
   } rsp_type;

endpackage

@@ rtl/refcount_delta_cache.sv @@
// Top level of the reference-count delta cache.
//
//  channel  ports                                         handshake
//  ------   --------------------------------------------  -----------------------
//  item in  req_opcode, req_object_id, req_epoch_now       push & !full
//  item out rsp_kind, rsp_evicted_id, rsp_evicted_delta,   pop & !empty
//           rsp_last
//
// Increment/decrement: slot read-modify-write (registered memory read, then
// write); no new item is taken before the write. Tick, new epoch: a walk of every
// slot, one per cycle while the result queue accepts, then a done record; else a
// skip record. Reset clears valid bits and the local epoch. A full result queue
// stalls the back end; a full command queue stalls the front and raises full.
`timescale 1ns / 1ps
`include "refcount_delta_cache_defines.svh"

module refcount_delta_cache import rdc_pkg::*; #(
   parameter int SLOTS     = 32,
   parameter int SLOT_BITS = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_opcode,
   input  logic [31:0]        req_object_id,
   input  logic [31:0]        req_epoch_now,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         rsp_kind,
   output logic [31:0]        rsp_evicted_id,
   output logic signed [31:0] rsp_evicted_delta,
   output logic               rsp_last
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CMD_W = $bits(cmd_type) + IDX_W;
   localparam int RSP_W = $bits(rsp_type);

   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
   logic             rsp_push, rsp_full;
   rsp_type          rsp_wdata;
   logic [RSP_W-1:0] rsp_rdata;
   rsp_type          rsp_head;

   rdc_front #(
      .SLOTS     (SLOTS),
      .SLOT_BITS (SLOT_BITS),
      .IDX_W     (IDX_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .opcode    (req_opcode),
      .object_id (req_object_id),
      .epoch_now (req_epoch_now),
      .cmd_push  (cmd_push),
      .cmd_full  (cmd_full),
      .cmd_data  (cmd_wdata)
   );

   rdc_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .full  (cmd_full),
      .wdata (cmd_wdata),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .rdata (cmd_rdata)
   );

   rdc_back #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_rdata),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata)
   );

   rdc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full),
      .wdata (rsp_wdata),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_rdata)
   );

   assign rsp_head          = rsp_type'(rsp_rdata);
   assign rsp_kind          = rsp_head.kind;
   assign rsp_evicted_id    = rsp_head.id;
   assign rsp_evicted_delta = rsp_head.delta;
   assign rsp_last          = rsp_head.last;

   `RDC_ASSERT_ALWAYS(a_cmd_no_overflow, clock, reset, !(cmd_push && cmd_full), "command queue overflow")
   `RDC_ASSERT_ALWAYS(a_rsp_no_overflow, clock, reset, !(rsp_push && rsp_full), "result queue overflow")
   `RDC_ASSERT_IMPLY(a_status_is_last, clock, reset, !empty && (rsp_kind != KIND_EVICT), rsp_last, "done/skip record without last")
   `RDC_ASSERT_IMPLY(a_empty_after_reset, clock, reset, $past(reset), empty && !cmd_push, "item present right after reset")

endmodule

@@ rtl/rdc_fifo.sv @@
// Small register FIFO used between front and back and on the result side.
`timescale 1ns / 1ps

module rdc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ rtl/rdc_front.sv @@
// Front end: accepts items, hashes the object id to a slot, drops unused opcodes.
`timescale 1ns / 1ps

module rdc_front import rdc_pkg::*; #(
   parameter int SLOTS     = 32,
   parameter int SLOT_BITS = 5,
   parameter int IDX_W     = $clog2(SLOTS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [1:0]                       opcode,
   input  logic [31:0]                      object_id,
   input  logic [31:0]                      epoch_now,
   output logic                             cmd_push,
   input  logic                             cmd_full,
   output logic [$bits(cmd_type)+IDX_W-1:0] cmd_data
);

   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_op_ff;
   logic [31:0]       s1_id_ff;
   logic [31:0]       s1_epoch_ff;
   logic [31:0]       s1_hash_ff;
   logic [31:0]       hash_in;
   logic              s1_is_cmd;
   logic              drain;
   logic [IDX_W-1:0]  slot;
   cmd_type           cmd;

   // remainder by SLOTS, one bit per step
   function automatic logic [IDX_W-1:0] reduce_slot(input logic [SLOT_BITS-1:0] h);
      logic [IDX_W:0] r;
      r = '0;
      for (int i = SLOT_BITS - 1; i >= 0; i--) begin
         r = {r[IDX_W-1:0], h[i]};
         if (r >= (IDX_W + 1)'(SLOTS)) begin
            r = r - (IDX_W + 1)'(SLOTS);
         end
      end
      return r[IDX_W-1:0];
   endfunction

   assign hash_in   = object_id * HASH_MUL;
   assign s1_is_cmd = (s1_op_ff == OP_INC) || (s1_op_ff == OP_DEC) || (s1_op_ff == OP_TICK);
   assign drain     = !s1_valid_ff || !s1_is_cmd || !cmd_full;
   assign full      = !drain;
   assign cmd_push  = s1_valid_ff && s1_is_cmd && !cmd_full;
   assign slot      = reduce_slot(s1_hash_ff[31 -: SLOT_BITS]);
   assign s1_valid_in = drain ? push : s1_valid_ff;

   always_comb begin
      cmd.op    = s1_op_ff;
      cmd.id    = s1_id_ff;
      cmd.epoch = s1_epoch_ff;
      cmd_data  = {cmd, slot};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (drain && push) begin
         s1_op_ff    <= opcode;
         s1_id_ff    <= object_id;
         s1_epoch_ff <= epoch_now;
         s1_hash_ff  <= hash_in;
      end
   end

endmodule

@@ rtl/rdc_back.sv @@
// Back end: slot read-modify-write, eviction, and the epoch flush walk.
`timescale 1ns / 1ps

module rdc_back import rdc_pkg::*; #(
   parameter int SLOTS = 32,
   parameter int IDX_W = $clog2(SLOTS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_empty,
   output logic                             cmd_pop,
   input  logic [$bits(cmd_type)+IDX_W-1:0] cmd_data,
   input  logic                             rsp_full,
   output logic                             rsp_push,
   output rsp_type                          rsp_data
);

   localparam int CMD_W = $bits(cmd_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPD,
      S_WALK,
      S_FINAL
   } state_type;

   state_type          state_ff;
   logic [1:0]         cur_op_ff;
   logic [31:0]        cur_id_ff;
   logic [IDX_W-1:0]   cur_slot_ff;
   logic [IDX_W-1:0]   walk_ff;
   kind_type           fin_kind_ff;
   logic [31:0]        epoch_ff;
   logic [SLOTS-1:0]   valid_ff;

   logic [31:0]        tag_mem_ff   [SLOTS];
   logic signed [31:0] delta_mem_ff [SLOTS];
   logic [31:0]        rd_tag_ff;
   logic signed [31:0] rd_delta_ff;

   cmd_type            head;
   logic [IDX_W-1:0]   head_slot;
   logic [IDX_W-1:0]   rd_addr;
   logic               slot_v, hit, evict, upd_go;
   logic signed [31:0] base, new_delta;
   logic               walk_emit, walk_adv, walk_last;
   logic               mem_we;

   assign head      = cmd_type'(cmd_data[CMD_W+IDX_W-1 -: CMD_W]);
   assign head_slot = cmd_data[IDX_W-1:0];
   assign cmd_pop   = (state_ff == S_IDLE) && !cmd_empty;

   assign slot_v = valid_ff[cur_slot_ff];
   assign hit    = slot_v && (rd_tag_ff == cur_id_ff);
   assign evict  = slot_v && !hit && (rd_delta_ff != '0);
   assign upd_go = !evict || !rsp_full;
   assign base   = hit ? rd_delta_ff : '0;

   always_comb begin
      if (cur_op_ff == OP_INC) begin
         new_delta = (base == DELTA_MAX) ? base : base + 32'sd1;
      end else begin
         new_delta = (base == DELTA_MIN) ? base : base - 32'sd1;
      end
   end

   assign walk_emit = valid_ff[walk_ff] && (rd_delta_ff != '0);
   assign walk_adv  = !walk_emit || !rsp_full;
   assign walk_last = (walk_ff == IDX_W'(SLOTS - 1));
   assign mem_we    = (state_ff == S_UPD) && upd_go;

   always_comb begin
      unique case (state_ff)
         S_IDLE:  rd_addr = (head.op == OP_TICK) ? '0 : head_slot;
         S_UPD:   rd_addr = cur_slot_ff;
         S_WALK:  rd_addr = (walk_adv && !walk_last) ? walk_ff + 1'b1 : walk_ff;
         default: rd_addr = cur_slot_ff;
      endcase
   end

   always_comb begin
      rsp_data.kind  = KIND_EVICT;
      rsp_data.id    = rd_tag_ff;
      rsp_data.delta = rd_delta_ff;
      rsp_data.last  = 1'b1;
      rsp_push       = 1'b0;
      unique case (state_ff)
         S_UPD: begin
            rsp_push = evict && !rsp_full;
         end
         S_WALK: begin
            rsp_push      = walk_emit && !rsp_full;
            rsp_data.last = 1'b0;
         end
         S_FINAL: begin
            rsp_push       = !rsp_full;
            rsp_data.kind  = fin_kind_ff;
            rsp_data.id    = '0;
            rsp_data.delta = '0;
         end
         default: begin
            rsp_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         epoch_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (!cmd_empty) begin
                  cur_op_ff   <= head.op;
                  cur_id_ff   <= head.id;
                  cur_slot_ff <= head_slot;
                  if (head.op == OP_TICK) begin
                     if (head.epoch == epoch_ff) begin
                        fin_kind_ff <= KIND_SKIP;
                        state_ff    <= S_FINAL;
                     end else begin
                        epoch_ff <= head.epoch;
                        walk_ff  <= '0;
                        state_ff <= S_WALK;
                     end
                  end else begin
                     state_ff <= S_UPD;
                  end
               end
            end
            S_UPD: begin
               if (upd_go) begin
                  valid_ff[cur_slot_ff] <= 1'b1;
                  state_ff              <= S_IDLE;
               end
            end
            S_WALK: begin
               if (walk_adv) begin
                  valid_ff[walk_ff] <= 1'b0;
                  if (walk_last) begin
                     fin_kind_ff <= KIND_DONE;
                     state_ff    <= S_FINAL;
                  end else begin
                     walk_ff <= walk_ff + 1'b1;
                  end
               end
            end
            S_FINAL: begin
               if (!rsp_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem_ff[cur_slot_ff]   <= cur_id_ff;
         delta_mem_ff[cur_slot_ff] <= new_delta;
      end
      rd_tag_ff   <= tag_mem_ff[rd_addr];
      rd_delta_ff <= delta_mem_ff[rd_addr];
   end

endmodule
